[hw/rtl/aph_pkg.sv]
`default_nettype none
package aph_pkg;

  localparam int TIME_WIDTH_DEF = 32;
  localparam int WEIGHT_W       = 17;
  localparam int DT_W           = 32;
  localparam int SPEED_W        = 16;
  localparam int CFG_AW         = 5;

  typedef enum logic [1:0] {
    KIND_TICK = 2'd0,
    KIND_PLAY = 2'd1,
    KIND_STOP = 2'd2,
    KIND_SET  = 2'd3
  } aph_kind_t;

  typedef enum logic [1:0] {
    LM_CYCLE    = 2'd0,
    LM_PINGPONG = 2'd1,
    LM_CLAMP    = 2'd2
  } aph_loop_t;

  typedef enum logic [2:0] {
    REG_START_TIME    = 3'd0,
    REG_END_TIME      = 3'd1,
    REG_SPEED         = 3'd2,
    REG_LOOP_MODE     = 3'd3,
    REG_START_WEIGHT  = 3'd4,
    REG_TARGET_WEIGHT = 3'd5,
    REG_BLEND_DELAY   = 3'd6
  } aph_reg_t;

  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_MSTEP  = 9'b000000010,
    ST_SUM    = 9'b000000100,
    ST_PLACE  = 9'b000001000,
    ST_MBLEND = 9'b000010000,
    ST_DINIT  = 9'b000100000,
    ST_DIV    = 9'b001000000,
    ST_WCHK   = 9'b010000000,
    ST_OUT    = 9'b100000000
  } aph_state_t;

endpackage
`default_nettype wire

[hw/rtl/animation_playhead_controller.sv]
`default_nettype none
// Animation playhead controller.
// Input channel (in_*): one beat per command. in_tuser carries the kind (tick, play,
// stop, set position); in_tdata carries tick_delta, play_forward and new_time.
// Output channel (out_*): exactly one beat per input beat, holding position, blend
// weight and the playing / reverse flags as they stand after the command.
// Configuration: APB-style port, registers at byte addresses 4*i, written with
// psel, penable and pwrite high; pready is tied high. Write only while idle.
// Sequence: a tick while playing passes MSTEP, SUM, PLACE and MBLEND, then DINIT,
// DIV (the 17-step restoring divider) and WCHK when a blend division is needed,
// or goes to OUT when the blend has run out. Set position passes PLACE, play,
// stop and a tick while stopped go to OUT directly. One command is in flight at a
// time; in_tready is low from acceptance until the result beat has been taken.
// A single 17x32 multiplier is shared: first for speed*delta, then for the weight
// difference times delta, feeding the divider.
// Reset (synchronous, rst_n low): registers to their defaults, position 0, weight
// 1.0, stopped, forward. If the receiver stalls the result beat is held and no new
// command is accepted.
module animation_playhead_controller #(
  parameter int TIME_WIDTH = aph_pkg::TIME_WIDTH_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  // in_tdata: [31:0] tick_delta, [32] play_forward, [64:33] new_time, [71:65] zero
  input  wire logic                       in_tvalid,
  output logic                            in_tready,
  input  wire logic [71:0]                in_tdata,
  // in_tuser: [1:0] kind
  input  wire logic [1:0]                 in_tuser,
  output logic                            out_tvalid,
  input  wire logic                       out_tready,
  // out_tdata: [31:0] position, [48:32] weight, [49] is_playing, [50] is_reverse,
  // [55:51] zero
  output logic [55:0]                     out_tdata,
  input  wire logic                       cfg_psel,
  input  wire logic                       cfg_penable,
  input  wire logic                       cfg_pwrite,
  input  wire logic [aph_pkg::CFG_AW-1:0] cfg_paddr,
  input  wire logic [31:0]                cfg_pwdata,
  output logic [31:0]                     cfg_prdata,
  output logic                            cfg_pready
);
  import aph_pkg::*;

  localparam int PT_W    = (TIME_WIDTH > 32) ? TIME_WIDTH : 32;
  localparam int PROD_W  = WEIGHT_W + DT_W;
  localparam int STEP_W  = PROD_W + 1 - 8;
  localparam int SW      = ((PT_W > STEP_W) ? PT_W : STEP_W) + 1;
  localparam int CNT_W   = $clog2(WEIGHT_W + 1);
  localparam logic [CNT_W-1:0] DIV_STEPS = CNT_W'(WEIGHT_W);
  localparam logic signed [SW-1:0] TMAX_S =
    {{(SW-TIME_WIDTH+1){1'b0}}, {(TIME_WIDTH-1){1'b1}}};
  localparam logic signed [SW-1:0] TMIN_S = ~TMAX_S;
  localparam logic [WEIGHT_W-1:0] ONE_W = WEIGHT_W'(65536);

  // configuration
  logic signed [31:0]        start_time_r, end_time_r;
  logic signed [SPEED_W-1:0] speed_r;
  logic [1:0]                loop_mode_r;
  logic [WEIGHT_W-1:0]       start_weight_r, target_weight_r;
  logic [DT_W-1:0]           blend_delay_r;

  // playhead state
  logic signed [PT_W-1:0]    play_time_r;
  logic [WEIGHT_W-1:0]       weight_r;
  logic [DT_W-1:0]           blend_rem_r;
  logic                      backward_r, playing_r;

  // sequencer and working registers
  aph_state_t                state_r, state_nxt;
  aph_kind_t                 kind_r, in_kind;
  logic [DT_W-1:0]           dt_r;
  logic [PROD_W-1:0]         prod_r;
  logic signed [PT_W-1:0]    cand_r;
  logic [DT_W-1:0]           drem_r;
  logic [WEIGHT_W-1:0]       dq_r;
  logic                      dneg_r;
  logic [CNT_W-1:0]          cnt_r;

  logic                      in_acc, cfg_wr;
  logic [SPEED_W-1:0]        speed_mag;
  logic signed [WEIGHT_W:0]  wdiff;
  logic [WEIGHT_W-1:0]       wdiff_mag, mul_a, wnew;
  logic [PROD_W-1:0]         mul_p;
  logic signed [PROD_W:0]    p_signed;
  logic signed [STEP_W-1:0]  step;
  logic signed [SW-1:0]      sum, sum_sat, nt_ext, nt_sat;
  logic signed [PT_W-1:0]    st_ext, en_ext;
  logic                      below, above, step_pos, step_neg;
  logic [DT_W:0]             dshift, dtrial;
  logic                      dfit;

  assign in_kind    = aph_kind_t'(in_tuser);
  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = (state_r == ST_OUT);
  assign out_tdata  = {5'b0, backward_r, playing_r, weight_r, play_time_r[31:0]};
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    case (aph_reg_t'(cfg_paddr[4:2]))
      REG_START_TIME:    cfg_prdata = start_time_r;
      REG_END_TIME:      cfg_prdata = end_time_r;
      REG_SPEED:         cfg_prdata = {16'b0, speed_r};
      REG_LOOP_MODE:     cfg_prdata = {30'b0, loop_mode_r};
      REG_START_WEIGHT:  cfg_prdata = {15'b0, start_weight_r};
      REG_TARGET_WEIGHT: cfg_prdata = {15'b0, target_weight_r};
      REG_BLEND_DELAY:   cfg_prdata = blend_delay_r;
      default:           cfg_prdata = 32'b0;
    endcase
  end

  // shared multiplier: |speed| * dt, then |target - weight| * dt
  assign speed_mag = speed_r[SPEED_W-1] ? SPEED_W'(-speed_r) : speed_r;
  assign wdiff     = signed'({1'b0, target_weight_r}) - signed'({1'b0, weight_r});
  assign wdiff_mag = wdiff[WEIGHT_W] ? WEIGHT_W'(-wdiff) : wdiff[WEIGHT_W-1:0];
  assign mul_a     = (state_r == ST_MSTEP) ? {1'b0, speed_mag} : wdiff_mag;
  assign mul_p     = {{DT_W{1'b0}}, mul_a} * {{WEIGHT_W{1'b0}}, dt_r};

  // signed step, floored to Q16.16
  assign p_signed = (speed_r[SPEED_W-1] ^ backward_r) ? -signed'({1'b0, prod_r})
                                                      :  signed'({1'b0, prod_r});
  assign step     = p_signed[PROD_W:8];
  assign step_neg = step[STEP_W-1];
  assign step_pos = !step[STEP_W-1] && (step != '0);
  assign sum      = SW'(play_time_r) + SW'(step);
  always_comb begin
    sum_sat = sum;
    if (step_pos && (sum > TMAX_S)) sum_sat = TMAX_S;
    else if (step_neg && (sum < TMIN_S)) sum_sat = TMIN_S;
  end

  assign nt_ext = SW'(signed'(in_tdata[64:33]));
  always_comb begin
    nt_sat = nt_ext;
    if (nt_ext > TMAX_S) nt_sat = TMAX_S;
    else if (nt_ext < TMIN_S) nt_sat = TMIN_S;
  end

  // range test
  assign st_ext = PT_W'(start_time_r);
  assign en_ext = PT_W'(end_time_r);
  assign below  = cand_r < st_ext;
  assign above  = cand_r > en_ext;

  // restoring divider step, one quotient bit a cycle
  assign dshift = {drem_r, dq_r[WEIGHT_W-1]};
  assign dtrial = dshift - {1'b0, blend_rem_r};
  assign dfit   = !dtrial[DT_W];
  assign wnew   = dneg_r ? (weight_r - dq_r) : (weight_r + dq_r);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_kind == KIND_SET) state_nxt = ST_PLACE;
          else if (in_kind == KIND_TICK && playing_r) state_nxt = ST_MSTEP;
          else state_nxt = ST_OUT;
        end
      end
      ST_MSTEP:  state_nxt = ST_SUM;
      ST_SUM:    state_nxt = ST_PLACE;
      ST_PLACE:  state_nxt = (kind_r == KIND_TICK) ? ST_MBLEND : ST_OUT;
      ST_MBLEND: state_nxt = (blend_rem_r <= dt_r) ? ST_OUT : ST_DINIT;
      ST_DINIT:  state_nxt = ST_DIV;
      ST_DIV:    state_nxt = (cnt_r == CNT_W'(1)) ? ST_WCHK : ST_DIV;
      ST_WCHK:   state_nxt = ST_OUT;
      ST_OUT:    state_nxt = out_tready ? ST_IDLE : ST_OUT;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // control and playhead state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_IDLE;
      start_time_r    <= '0;
      end_time_r      <= 32'sd65536;
      speed_r         <= 16'sd256;
      loop_mode_r     <= LM_CYCLE;
      start_weight_r  <= ONE_W;
      target_weight_r <= ONE_W;
      blend_delay_r   <= '0;
      play_time_r     <= '0;
      weight_r        <= ONE_W;
      blend_rem_r     <= '0;
      backward_r      <= 1'b0;
      playing_r       <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr) begin
        case (aph_reg_t'(cfg_paddr[4:2]))
          REG_START_TIME:    start_time_r    <= cfg_pwdata;
          REG_END_TIME:      end_time_r      <= cfg_pwdata;
          REG_SPEED:         speed_r         <= cfg_pwdata[15:0];
          REG_LOOP_MODE:     loop_mode_r     <= cfg_pwdata[1:0];
          REG_START_WEIGHT:  start_weight_r  <= cfg_pwdata[16:0];
          REG_TARGET_WEIGHT: target_weight_r <= cfg_pwdata[16:0];
          REG_BLEND_DELAY:   blend_delay_r   <= cfg_pwdata;
          default: ;
        endcase
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            unique case (in_kind)
              KIND_PLAY: begin
                backward_r  <= !in_tdata[32];
                playing_r   <= 1'b1;
                weight_r    <= start_weight_r;
                blend_rem_r <= blend_delay_r;
              end
              KIND_STOP: playing_r <= 1'b0;
              KIND_TICK, KIND_SET: ;
            endcase
          end
        end
        ST_PLACE: begin
          if (below || above) begin
            case (aph_loop_t'(loop_mode_r))
              LM_CYCLE: play_time_r <= st_ext;
              LM_PINGPONG: begin
                backward_r  <= !backward_r;
                play_time_r <= below ? st_ext : en_ext;
              end
              LM_CLAMP: begin
                if (below) begin
                  play_time_r <= st_ext;
                end else begin
                  play_time_r <= en_ext;
                  playing_r   <= 1'b0;
                end
              end
              default: play_time_r <= cand_r;   // unused mode: no range rule
            endcase
          end else begin
            play_time_r <= cand_r;
          end
        end
        ST_MBLEND: begin
          if (blend_rem_r <= dt_r) begin
            weight_r    <= target_weight_r;
            blend_rem_r <= '0;
            if (target_weight_r == '0) playing_r <= 1'b0;
          end
        end
        ST_WCHK: begin
          weight_r    <= wnew;
          blend_rem_r <= blend_rem_r - dt_r;
          if ((wnew == '0) && (target_weight_r == '0)) playing_r <= 1'b0;
        end
        ST_MSTEP, ST_SUM, ST_DINIT, ST_DIV, ST_OUT: ;
      endcase
    end
  end

  // working registers, no reset needed
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          kind_r <= in_kind;
          dt_r   <= in_tdata[31:0];
          cand_r <= PT_W'(nt_sat);
        end
      end
      ST_MSTEP: prod_r <= mul_p;
      ST_SUM:   cand_r <= PT_W'(sum_sat);
      ST_MBLEND: begin
        prod_r <= mul_p;
        dneg_r <= wdiff[WEIGHT_W];
      end
      ST_DINIT: begin
        // quotient is below 2^17 as dt < remaining, so the top bits start as remainder
        drem_r <= prod_r[PROD_W-1:WEIGHT_W];
        dq_r   <= prod_r[WEIGHT_W-1:0];
        cnt_r  <= DIV_STEPS;
      end
      ST_DIV: begin
        drem_r <= dfit ? dtrial[DT_W-1:0] : dshift[DT_W-1:0];
        dq_r   <= {dq_r[WEIGHT_W-2:0], dfit};
        cnt_r  <= cnt_r - CNT_W'(1);
      end
      ST_PLACE, ST_WCHK, ST_OUT: ;
    endcase
  end

endmodule
`default_nettype wire

[hw/rtl/aph_checker.sv]
`default_nettype none
module aph_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [55:0] out_tdata
);
  import aph_pkg::*;

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat dropped or changed while stalled");

  // one command in flight: never ready while a result is pending
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("ready while a result is pending");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("accepted a second beat back to back");

  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready |=> !out_tvalid && in_tready)
    else $error("extra result or no return to ready");

endmodule

bind animation_playhead_controller aph_checker u_aph_checker (.*);
`default_nettype wire
